// File: hdl/waypoint_segment_sampler_core_assert.svh
// Assertion macros used by the bound checker in hdl/wss_checker.sv.
`ifndef WAYPOINT_SEGMENT_SAMPLER_CORE_ASSERT_SVH
`define WAYPOINT_SEGMENT_SAMPLER_CORE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define WSS_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
	else $error(msg);
// Next-cycle implication.
`define WSS_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
	else $error(msg);
`endif

// File: hdl/wss_pkg.sv
package wss_pkg;
	localparam int unsigned CoordW = 17;
	localparam int unsigned MaxSamplesDef = 64;
	localparam int unsigned SqW = 36;   // dx*dx + dz*dz
	localparam int unsigned RadW = 62;  // S * 2^26
	localparam int unsigned MagW = 31;  // isqrt of RadW-bit value
	localparam int unsigned NumW = 54;  // |d| << 36
	localparam int unsigned AccW = 56;  // position << 16 plus increments
	localparam int unsigned FracBits = 16;
	localparam logic ActStart = 1'b0;
	localparam logic ActWaypoint = 1'b1;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_MULX  = 8'b00000010,
		ST_MULZ  = 8'b00000100,
		ST_SQRTC = 8'b00001000,
		ST_SQRTM = 8'b00010000,
		ST_DIVX  = 8'b00100000,
		ST_DIVZ  = 8'b01000000,
		ST_EMIT  = 8'b10000000
	} state_t;
endpackage

// File: hdl/waypoint_segment_sampler_core.sv
// Channel | Dir | tdata fields (low bit up)              | tuser
// s_axis  | in  | target_x[16:0], target_z[33:17], 0 pad | action
// m_axis  | out | sample_x[16:0], sample_z[33:17], 0 pad | truncated; tlast = last
// A start item puts its word on m_axis in the cycle after acceptance.
// A waypoint item runs bit-serially: two shift-add multiply passes, two square roots and
// two restoring divides, then one word per cycle while m_axis_tready is high.
// A waypoint item that yields no samples frees the input after the first square root.
// arst_n clears control and the current position to zero.
// A stalled output word holds; the next item is taken only after the run ends.
module waypoint_segment_sampler_core #(
	parameter int unsigned MAX_SAMPLES = wss_pkg::MaxSamplesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // target_x, target_z, zero pad
	input  logic        s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // sample_x, sample_z, zero pad
	output logic        m_axis_tlast,  // last
	output logic        m_axis_tuser   // truncated
);
	localparam int unsigned CW = wss_pkg::CoordW;
	localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned BitW = 6;

	wss_pkg::state_t state_q;
	logic signed [CW-1:0] cur_x_q, cur_z_q;
	logic signed [CW:0] dx_q, dz_q;
	logic [CW-1:0] mplier_q;
	logic [wss_pkg::SqW-1:0] mcand_q;
	// Accumulates dx*dx + dz*dz and keeps it for the second square root.
	logic [wss_pkg::SqW-1:0] prod_q;
	logic [BitW-1:0] bit_q;
	// Shared digit-by-digit square root.
	logic [wss_pkg::RadW+1:0] rad_q;
	logic [wss_pkg::MagW+1:0] rem_q;
	logic [wss_pkg::MagW-1:0] root_q, mag_q;
	logic [CntW-1:0] n_q, k_q;
	logic trunc_q;
	// Shared restoring divider.
	logic [wss_pkg::NumW-1:0] num_q;
	logic [wss_pkg::MagW:0] drem_q;
	logic [wss_pkg::NumW-1:0] quo_q;
	logic signed [wss_pkg::AccW-1:0] inc_x_q, inc_z_q, acc_x_q, acc_z_q;
	logic signed [CW-1:0] out_x_q, out_z_q;
	logic out_last_q, out_tr_q, out_v_q;

	logic [CW:0] ab;
	logic [CW-1:0] m_cur;
	logic [wss_pkg::SqW-1:0] c_cur, prod_nx;
	logic [wss_pkg::MagW+1:0] trial, rem_sh, rem_nx;
	logic sq_ge;
	logic [wss_pkg::MagW-1:0] root_nx;
	logic signed [CW:0] dsel;
	logic [CW:0] dabs;
	logic [wss_pkg::NumW-1:0] nm, qv, quo_nx;
	logic [wss_pkg::MagW:0] dr, drem_nx;
	logic [wss_pkg::MagW+1:0] ds, dt;
	logic dge;
	logic signed [wss_pkg::AccW-1:0] nx, nz;
	logic signed [CW-1:0] rx, rz;
	logic out_free, s_fire, out_load, last_nx;

	function automatic logic signed [CW-1:0] round_sat(
		input logic signed [wss_pkg::AccW-1:0] a);
		logic signed [wss_pkg::AccW-1:0] b;
		logic signed [wss_pkg::AccW-wss_pkg::FracBits-1:0] v;
		b = a + (wss_pkg::AccW'(1) <<< (wss_pkg::FracBits - 1));
		v = b[wss_pkg::AccW-1:wss_pkg::FracBits];
		if (v > (wss_pkg::AccW-wss_pkg::FracBits)'(65535))
			return CW'(65535);
		else if (v < -(wss_pkg::AccW-wss_pkg::FracBits)'(65536))
			return CW'(-65536);
		return v[CW-1:0];
	endfunction

	assign out_free = !out_v_q || m_axis_tready;
	assign s_axis_tready = (state_q == wss_pkg::ST_IDLE) && out_free;
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign dsel = (state_q == wss_pkg::ST_DIVX) ? dx_q : dz_q;
	assign last_nx = (k_q + 1'b1) == n_q;
	assign out_load = (s_fire && s_axis_tuser == wss_pkg::ActStart)
		|| (state_q == wss_pkg::ST_EMIT && out_free);

	always_comb begin
		// Shift-add multiply of |d| by itself, one multiplier bit a cycle.
		ab = (state_q == wss_pkg::ST_MULX)
			? (dx_q[CW] ? (CW+1)'(-dx_q) : dx_q)
			: (dz_q[CW] ? (CW+1)'(-dz_q) : dz_q);
		m_cur = (bit_q == '0) ? ab[CW-1:0] : mplier_q;
		c_cur = (bit_q == '0) ? wss_pkg::SqW'(ab) : mcand_q;
		prod_nx = prod_q + (m_cur[0] ? c_cur : '0);

		// Square root, two radicand bits a cycle.
		rem_sh = {rem_q[wss_pkg::MagW-1:0], rad_q[wss_pkg::RadW+1:wss_pkg::RadW]};
		trial = {root_q, 2'b01};
		sq_ge = rem_sh >= trial;
		rem_nx = sq_ge ? rem_sh - trial : rem_sh;
		root_nx = {root_q[wss_pkg::MagW-2:0], sq_ge};

		// Restoring divide of (|d|<<36 + mag/2) by mag; the low 36 bits of |d|<<36
		// are zero, so the rounding half just fills them.
		dabs = dsel[CW] ? (CW+1)'(-dsel) : dsel;
		if (bit_q == '0) begin
			nm = {dabs, (wss_pkg::NumW - CW - wss_pkg::MagW)'(0),
				mag_q[wss_pkg::MagW-1:1]};
			dr = '0;
			qv = '0;
		end else begin
			nm = num_q;
			dr = drem_q;
			qv = quo_q;
		end
		ds = {dr, nm[wss_pkg::NumW-1]};
		dt = ds - {2'b00, mag_q};
		dge = !dt[wss_pkg::MagW+1];
		drem_nx = dge ? dt[wss_pkg::MagW:0] : ds[wss_pkg::MagW:0];
		quo_nx = {qv[wss_pkg::NumW-2:0], dge};

		nx = acc_x_q + inc_x_q;
		nz = acc_z_q + inc_z_q;
		rx = round_sat(nx);
		rz = round_sat(nz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wss_pkg::ST_IDLE;
			cur_x_q <= '0;
			cur_z_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_load)
				out_v_q <= 1'b1;
			else if (m_axis_tready)
				out_v_q <= 1'b0;
			case (state_q)
				wss_pkg::ST_IDLE: begin
					if (s_fire) begin
						if (s_axis_tuser == wss_pkg::ActStart) begin
							cur_x_q <= s_axis_tdata[CW-1:0];
							cur_z_q <= s_axis_tdata[2*CW-1:CW];
							out_x_q <= s_axis_tdata[CW-1:0];
							out_z_q <= s_axis_tdata[2*CW-1:CW];
							out_last_q <= 1'b1;
							out_tr_q <= 1'b0;
						end else begin
							dx_q <= $signed({s_axis_tdata[CW-1], s_axis_tdata[CW-1:0]})
								- $signed({cur_x_q[CW-1], cur_x_q});
							dz_q <= $signed({s_axis_tdata[2*CW-1], s_axis_tdata[2*CW-1:CW]})
								- $signed({cur_z_q[CW-1], cur_z_q});
							bit_q <= '0;
							prod_q <= '0;
							state_q <= wss_pkg::ST_MULX;
						end
					end
				end
				wss_pkg::ST_MULX, wss_pkg::ST_MULZ: begin
					prod_q <= prod_nx;
					mplier_q <= m_cur >> 1;
					mcand_q <= c_cur << 1;
					if (bit_q == BitW'(CW - 1)) begin
						bit_q <= '0;
						if (state_q == wss_pkg::ST_MULX)
							state_q <= wss_pkg::ST_MULZ;
						else begin
							rad_q <= {prod_nx, (wss_pkg::RadW + 2 - wss_pkg::SqW)'(0)};
							rem_q <= '0;
							root_q <= '0;
							state_q <= wss_pkg::ST_SQRTC;
						end
					end else
						bit_q <= bit_q + 1'b1;
				end
				wss_pkg::ST_SQRTC, wss_pkg::ST_SQRTM: begin
					if (state_q == wss_pkg::ST_SQRTC && bit_q == BitW'(wss_pkg::SqW/2 - 1)) begin
						bit_q <= '0;
						if (root_nx[wss_pkg::MagW-1:7] == '0)
							state_q <= wss_pkg::ST_IDLE;
						else begin
							if (root_nx[wss_pkg::MagW-1:7] > (wss_pkg::MagW-7)'(MAX_SAMPLES)) begin
								n_q <= CntW'(MAX_SAMPLES);
								trunc_q <= 1'b1;
							end else begin
								n_q <= root_nx[CntW+6:7];
								trunc_q <= 1'b0;
							end
							rad_q <= {prod_q, (wss_pkg::RadW + 2 - wss_pkg::SqW)'(0)};
							rem_q <= '0;
							root_q <= '0;
							state_q <= wss_pkg::ST_SQRTM;
						end
					end else if (state_q == wss_pkg::ST_SQRTM
						&& bit_q == BitW'(wss_pkg::MagW - 1)) begin
						bit_q <= '0;
						mag_q <= root_nx;
						state_q <= wss_pkg::ST_DIVX;
					end else begin
						bit_q <= bit_q + 1'b1;
						rem_q <= rem_nx;
						root_q <= root_nx;
						rad_q <= rad_q << 2;
					end
				end
				wss_pkg::ST_DIVX, wss_pkg::ST_DIVZ: begin
					drem_q <= drem_nx;
					quo_q <= quo_nx;
					num_q <= nm << 1;
					if (bit_q == BitW'(wss_pkg::NumW - 1)) begin
						bit_q <= '0;
						if (state_q == wss_pkg::ST_DIVX) begin
							inc_x_q <= dsel[CW] ? -wss_pkg::AccW'(quo_nx) : wss_pkg::AccW'(quo_nx);
							state_q <= wss_pkg::ST_DIVZ;
						end else begin
							inc_z_q <= dsel[CW] ? -wss_pkg::AccW'(quo_nx) : wss_pkg::AccW'(quo_nx);
							acc_x_q <= wss_pkg::AccW'(cur_x_q) <<< wss_pkg::FracBits;
							acc_z_q <= wss_pkg::AccW'(cur_z_q) <<< wss_pkg::FracBits;
							k_q <= '0;
							state_q <= wss_pkg::ST_EMIT;
						end
					end else
						bit_q <= bit_q + 1'b1;
				end
				wss_pkg::ST_EMIT: begin
					if (out_free) begin
						acc_x_q <= nx;
						acc_z_q <= nz;
						out_x_q <= rx;
						out_z_q <= rz;
						out_last_q <= last_nx;
						out_tr_q <= last_nx && trunc_q;
						k_q <= k_q + 1'b1;
						if (last_nx) begin
							cur_x_q <= rx;
							cur_z_q <= rz;
							state_q <= wss_pkg::ST_IDLE;
						end
					end
				end
				default: state_q <= wss_pkg::ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {6'b0, out_z_q, out_x_q};
	assign m_axis_tlast = out_last_q;
	assign m_axis_tuser = out_tr_q;
endmodule

// File: hdl/wss_checker.sv
`include "waypoint_segment_sampler_core_assert.svh"
module wss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        m_axis_tuser
);
	logic held, tr_v, mid_run;

	assign held = m_axis_tvalid && !m_axis_tready;
	assign tr_v = m_axis_tvalid && m_axis_tuser;
	assign mid_run = m_axis_tvalid && !m_axis_tlast;

	// A word held under backpressure keeps its payload.
	`WSS_ASSERT_NXT(a_hold, clk, arst_n, held, m_axis_tvalid && $stable(m_axis_tdata), "word changed")
	// The truncated flag only rides on the last word of a run.
	`WSS_ASSERT_IMP(a_trunc_last, clk, arst_n, tr_v, m_axis_tlast, "truncated without last")
	// Pad bits stay zero.
	`WSS_ASSERT_IMP(a_pad, clk, arst_n, m_axis_tvalid, m_axis_tdata[39:34] == 6'b0, "pad bits set")
	// No new item is taken while a non-last word waits.
	`WSS_ASSERT_IMP(a_busy, clk, arst_n, mid_run, !s_axis_tready, "input taken mid-run")
endmodule

bind waypoint_segment_sampler_core wss_checker u_wss_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tlast(m_axis_tlast),
	.m_axis_tuser(m_axis_tuser)
);

// File: tb/waypoint_segment_sampler_checker.sv
`timescale 1ns / 1ps

module waypoint_segment_sampler_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // target_x, target_z, zero pad
	input  logic        s_axis_tuser,  // action
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,  // sample_x, sample_z, zero pad
	input  logic        m_axis_tlast,  // last
	input  logic        m_axis_tuser,  // truncated
	output int          fail_count,
	output int          pending,
	output int          words_seen,
	output int          cut_runs
);
	localparam int unsigned CoordW = wss_pkg::CoordW;

	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] z;
		logic                     last;
		logic                     truncated;
	} sample_t;

	sample_t sample_q[$];
	logic signed [CoordW-1:0] pos_x, pos_z;

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// Per-step increment with 16 fraction bits below the coordinate LSB.
	function automatic longint step_of(longint d, longint unsigned mag);
		longint unsigned a, q;
		a = (d < 0) ? longint'(-d) : longint'(d);
		q = ((a << 36) + (mag >> 1)) / mag;
		return (d < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic signed [CoordW-1:0] round_clip(longint acc);
		longint v;
		v = (acc + (64'sd1 <<< 15)) >>> 16;
		if (v > 65535) v = 65535;
		if (v < -65536) v = -65536;
		return v[CoordW-1:0];
	endfunction

	task automatic predict_samples(logic act, logic signed [CoordW-1:0] tx,
			logic signed [CoordW-1:0] tz);
		longint dx, dz, ix, iz, ax, az;
		longint unsigned sq, cnt, mag;
		int n;
		logic cut;
		sample_t s;
		if (act == wss_pkg::ActStart) begin
			pos_x = tx;
			pos_z = tz;
			s = '{x: tx, z: tz, last: 1'b1, truncated: 1'b0};
			sample_q = {sample_q, s};
			return;
		end
		dx = longint'(tx) - longint'(pos_x);
		dz = longint'(tz) - longint'(pos_z);
		sq = dx * dx + dz * dz;
		if (sq == 0) return;
		cnt = int_sqrt(sq) >> 7;
		if (cnt == 0) return;
		cut = cnt > wss_pkg::MaxSamplesDef;
		n = cut ? wss_pkg::MaxSamplesDef : int'(cnt);
		if (cut) cut_runs++;
		mag = int_sqrt(sq << 26);
		ix = step_of(dx, mag);
		iz = step_of(dz, mag);
		ax = longint'(pos_x) * 65536;
		az = longint'(pos_z) * 65536;
		for (int k = 0; k < n; k++) begin
			ax += ix;
			az += iz;
			s.x = round_clip(ax);
			s.z = round_clip(az);
			s.last = (k == n - 1);
			s.truncated = (k == n - 1) && cut;
			sample_q = {sample_q, s};
		end
		pos_x = s.x;
		pos_z = s.z;
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		words_seen = 0;
		cut_runs = 0;
		pending = 0;
		pos_x = '0;
		pos_z = '0;
	end

	always @(posedge clk) begin
		sample_t want;
		logic signed [CoordW-1:0] gx, gz;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				predict_samples(s_axis_tuser, s_axis_tdata[16:0], s_axis_tdata[33:17]);
			if (m_axis_tvalid && m_axis_tready) begin
				words_seen++;
				gx = m_axis_tdata[16:0];
				gz = m_axis_tdata[33:17];
				if (sample_q.size() == 0) begin
					report_mismatch("unexpected word", 1, 0);
				end else begin
					want = sample_q.pop_front();
					if (gx !== want.x) report_mismatch("sample_x", gx, want.x);
					if (gz !== want.z) report_mismatch("sample_z", gz, want.z);
					if (m_axis_tlast !== want.last)
						report_mismatch("last", m_axis_tlast, want.last);
					if (m_axis_tuser !== want.truncated)
						report_mismatch("truncated", m_axis_tuser, want.truncated);
					if (m_axis_tdata[39:34] !== '0) report_mismatch("pad", m_axis_tdata[39:34], 0);
				end
			end
		end
		pending = sample_q.size();
	end
endmodule

// File: tb/waypoint_segment_sampler_core_test.sv
`timescale 1ns / 1ps

module waypoint_segment_sampler_core_test;
	localparam int StallLimit = 6000;
	localparam int RandomItems = 390;
	localparam int QuietFrom = 340;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;  // target_x, target_z, zero pad
	logic        s_axis_tuser;  // action
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;  // sample_x, sample_z, zero pad
	logic        m_axis_tlast;  // last
	logic        m_axis_tuser;  // truncated

	int  fail_count, pending, words_seen, cut_runs;
	int  items_sent;
	bit  quiet;      // no idling on either side
	bit  long_hold;  // receiver holds off for a long stretch
	int  idle_cycles;
	int  prev_x, prev_z;

	waypoint_segment_sampler_core dut (.*);

	waypoint_segment_sampler_checker checker_i (.*);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: random bursts of back-pressure, plus one long hold-off on request.
	initial begin
		int run;
		m_axis_tready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				repeat (500) @(posedge clk);
				long_hold = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				run = $urandom_range(1, 11);
				m_axis_tready <= 1'b0;
				repeat (run) @(posedge clk);
			end else begin
				run = $urandom_range(1, 20);
				m_axis_tready <= 1'b1;
				repeat (run) @(posedge clk);
			end
		end
	end

	// Cycles with no word moving on either side.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= StallLimit) begin
			$display("watchdog expired with %0d words outstanding", pending);
			$display("waypoint_segment_sampler_core_test NOT OK");
			$finish;
		end
	end

	task automatic send_word(logic act, int x, int z);
		logic [16:0] bx, bz;
		bx = x[16:0];
		bz = z[16:0];
		if (!quiet && $urandom_range(0, 2) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {6'b0, bz, bx};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		items_sent++;
		prev_x = x;
		prev_z = z;
	endtask

	function automatic int clamp17(int v);
		if (v > 65535) return 65535;
		if (v < -65536) return -65536;
		return v;
	endfunction

	initial begin
		int mode, span;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = wss_pkg::ActStart;
		quiet = 1'b0;
		long_hold = 1'b0;
		items_sent = 0;
		idle_cycles = 0;
		prev_x = 0;
		prev_z = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Waypoint straight after reset samples from the origin and lands on the waypoint exactly.
		send_word(wss_pkg::ActWaypoint, 256, 0);
		send_word(wss_pkg::ActWaypoint, prev_x, prev_z);       // zero distance
		send_word(wss_pkg::ActWaypoint, prev_x + 90, prev_z);  // under two inches
		send_word(wss_pkg::ActWaypoint, prev_x + 127, prev_z - 90); // over two inches
		send_word(wss_pkg::ActStart, 0, 0);
		send_word(wss_pkg::ActWaypoint, 0, 128);               // exactly two inches
		send_word(wss_pkg::ActWaypoint, -200, -700);
		send_word(wss_pkg::ActStart, -65536, -65536);
		send_word(wss_pkg::ActWaypoint, 65535, 65535);         // long diagonal, cut at the cap
		send_word(wss_pkg::ActStart, 65535, -65536);
		send_word(wss_pkg::ActWaypoint, -65536, 65535);
		send_word(wss_pkg::ActStart, 65535, 65535);
		send_word(wss_pkg::ActWaypoint, 65535, 65535 - 64 * 128);      // exactly the cap
		send_word(wss_pkg::ActWaypoint, 65535, prev_z - 65 * 128);     // one over the cap
		send_word(wss_pkg::ActStart, 0, 0);
		send_word(wss_pkg::ActWaypoint, -1000, 0);
		send_word(wss_pkg::ActWaypoint, -1000, 3000);
		send_word(wss_pkg::ActStart, 65535, 0);
		send_word(wss_pkg::ActWaypoint, 65535, 2000);          // along the upper x bound
		send_word(wss_pkg::ActStart, -43691, 21845);           // alternating bit patterns

		for (int i = 0; i < RandomItems; i++) begin
			if (i == 100) long_hold = 1'b1;
			if (i == QuietFrom) quiet = 1'b1;
			mode = $urandom_range(0, 19);
			if (mode == 0)
				send_word(wss_pkg::ActStart, int'($urandom_range(0, 131071)) - 65536,
					int'($urandom_range(0, 131071)) - 65536);
			else if (mode == 1)
				send_word(wss_pkg::ActWaypoint, int'($urandom_range(0, 131071)) - 65536,
					int'($urandom_range(0, 131071)) - 65536);
			else if (mode == 2)
				send_word(wss_pkg::ActStart, int'($urandom_range(0, 2000)) - 1000,
					int'($urandom_range(0, 2000)) - 1000);
			else begin
				span = (mode < 10) ? 300 : (mode < 18) ? 3000 : 12000;
				send_word(wss_pkg::ActWaypoint,
					clamp17(prev_x + int'($urandom_range(0, 2 * span)) - span),
					clamp17(prev_z + int'($urandom_range(0, 2 * span)) - span));
			end
		end
		s_axis_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);

		$display("%0d items sent, %0d sample words checked, %0d runs cut at the cap",
			items_sent, words_seen, cut_runs);
		if (fail_count == 0) begin
			$display("waypoint_segment_sampler_core_test OK");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("waypoint_segment_sampler_core_test NOT OK");
		end
		$finish;
	end
endmodule
